@@ sv/mmn_pkg.sv @@
// shared types and constants for the min/max normalizer
// no dependencies; used by mmn_div and min_max_normalizer
`timescale 1ns / 1ps

package mmn_pkg;

   localparam int SAMPLE_W = 32;              // signed q16.16 sample
   localparam int NORM_W   = 17;              // unsigned q1.16 result, 1.0 included
   localparam int WEIGHT_W = 17;              // unsigned q1.16 weight
   localparam int AXIS_W   = 3;
   localparam int ACOUNT_W = 4;
   localparam int RANGE_W  = SAMPLE_W + 1;    // max - min as unsigned
   localparam int PROD_W   = RANGE_W + WEIGHT_W;
   localparam int QUO_W    = WEIGHT_W;        // quotient never exceeds the weight
   localparam int DCNT_W   = $clog2(QUO_W + 1);
   localparam int CSR_W    = 17;

   localparam logic [NORM_W-1:0]   ONE_Q16    = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 17'h1FFFF;

   // configuration register indexes
   localparam logic CSR_WEIGHT_DECAY = 1'b0;
   localparam logic CSR_AXIS_COUNT   = 1'b1;

   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  num;
      logic [RANGE_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quot;
   } div_rsp_type;

endpackage

@@ sv/mmn_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on mmn_pkg; the quotient is known to fit in QUO_W bits
`timescale 1ns / 1ps

module mmn_div (
   input  logic                clock,
   input  logic                reset,
   input  mmn_pkg::div_req_type req,
   output mmn_pkg::div_rsp_type rsp
);

   logic [mmn_pkg::RANGE_W-1:0] rem_ff, rem_in;
   logic [mmn_pkg::QUO_W-1:0]   low_ff, low_in;
   logic [mmn_pkg::RANGE_W-1:0] den_ff, den_in;
   logic [mmn_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [mmn_pkg::RANGE_W:0]   trial;
   logic                        qbit;

   // shift in next numerator bit, subtract when it fits
   assign trial = {rem_ff, low_ff[mmn_pkg::QUO_W-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = req.num[mmn_pkg::PROD_W-1:mmn_pkg::QUO_W];
         low_in = req.num[mmn_pkg::QUO_W-1:0];
         den_in = req.den;
         cnt_in = mmn_pkg::DCNT_W'(mmn_pkg::QUO_W);
      end else if (cnt_ff != '0) begin
         if (qbit) begin
            rem_in = mmn_pkg::RANGE_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[mmn_pkg::RANGE_W-1:0];
         end
         low_in  = {low_ff[mmn_pkg::QUO_W-2:0], qbit};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == mmn_pkg::DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = low_ff;

endmodule

@@ sv/min_max_normalizer.sv @@
// min/max normalizer top level: sample store, running min/max, emission pass
// depends on mmn_pkg and mmn_div; an item is loaded whenever start is high and busy low
// the item marked last starts the emission pass: the range is taken once, then each
// stored item in turn goes through the steps of the one-bit-per-cycle divider path
// (read, multiply, launch, 17 divide steps, result); weight and axis update as the
// final result goes out, start is taken from the next cycle; sync reset, no stall
`timescale 1ns / 1ps

module min_max_normalizer #(
   parameter int MAX_SAMPLES = 64,
   parameter int MAX_AXES    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // item input
   input  logic                           start,
   output logic                           busy,
   input  logic signed [mmn_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                           req_last,
   // results
   output logic                           rsp_valid,
   output logic [mmn_pkg::NORM_W-1:0]     rsp_normalized,
   output logic [mmn_pkg::AXIS_W-1:0]     rsp_axis_number,
   output logic                           rsp_end_of_set,
   output logic                           rsp_overflow,
   // configuration
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [mmn_pkg::CSR_W-1:0]      csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_RANGE  = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_LAUNCH = 3'd4;
   localparam logic [2:0] S_WAIT   = 3'd5;
   localparam logic [2:0] S_WRAP   = 3'd6;

   // sample store, one write port (load) and one registered read port (emit)
   logic [mmn_pkg::SAMPLE_W-1:0] store_mem [MAX_SAMPLES];
   logic [mmn_pkg::SAMPLE_W-1:0] rd_data_ff;

   logic [2:0]                          state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [ADDR_W-1:0]                   idx_ff, idx_in;
   logic signed [mmn_pkg::SAMPLE_W-1:0] min_ff, min_in;
   logic signed [mmn_pkg::SAMPLE_W-1:0] max_ff, max_in;
   logic                                dropped_ff, dropped_in;
   logic [mmn_pkg::WEIGHT_W-1:0]        weight_ff, weight_in;
   logic [mmn_pkg::AXIS_W-1:0]          axis_ff, axis_in;
   logic [mmn_pkg::WEIGHT_W-1:0]        decay_ff;
   logic [mmn_pkg::ACOUNT_W-1:0]        acount_ff;
   logic [mmn_pkg::RANGE_W-1:0]         range_ff;
   logic [mmn_pkg::PROD_W-1:0]          prod_ff;

   // result register
   logic                                rvalid_ff, rvalid_in;
   logic [mmn_pkg::NORM_W-1:0]          rnorm_ff, rnorm_in;
   logic                                reos_ff, reos_in;

   logic                                accept;
   logic                                full;
   logic                                store_wr;
   logic                                last_idx;
   logic [mmn_pkg::RANGE_W-1:0]         diff;
   logic [mmn_pkg::PROD_W-1:0]          prod_full;
   logic [mmn_pkg::NORM_W-1:0]          quot_clamped;
   logic [2*mmn_pkg::WEIGHT_W-1:0]      wprod;
   logic [mmn_pkg::WEIGHT_W-1:0]        wnext;
   logic [mmn_pkg::ACOUNT_W-1:0]        limit;
   mmn_pkg::div_req_type                div_req;
   mmn_pkg::div_rsp_type                div_rsp;

   assign busy     = (state_ff != S_LOAD);
   assign accept   = start && !busy;
   assign full     = (count_ff == CNT_W'(MAX_SAMPLES));
   assign store_wr = accept && !full;
   assign last_idx = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // offset from the minimum, never negative
   assign diff = mmn_pkg::RANGE_W'({rd_data_ff[mmn_pkg::SAMPLE_W-1], rd_data_ff}
                                   - {min_ff[mmn_pkg::SAMPLE_W-1], min_ff});
   assign prod_full = diff * weight_ff;

   assign div_req.start = (state_ff == S_LAUNCH);
   assign div_req.num   = prod_ff;
   assign div_req.den   = range_ff;

   mmn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // zero range gives zero, otherwise clamp at 1.0
   always_comb begin
      if (range_ff == '0) begin
         quot_clamped = '0;
      end else if (div_rsp.quot > mmn_pkg::ONE_Q16) begin
         quot_clamped = mmn_pkg::ONE_Q16;
      end else begin
         quot_clamped = div_rsp.quot;
      end
   end

   // next weight, floor(weight * decay / 1.0) saturated
   assign wprod = weight_ff * decay_ff;
   assign wnext = (wprod[2*mmn_pkg::WEIGHT_W-1:mmn_pkg::WEIGHT_W+16] != '0)
                  ? mmn_pkg::WEIGHT_MAX : wprod[mmn_pkg::WEIGHT_W+15:16];

   // effective axis count, zero acts as one, capped at MAX_AXES
   always_comb begin
      if (acount_ff == '0) begin
         limit = mmn_pkg::ACOUNT_W'(1);
      end else if (acount_ff > mmn_pkg::ACOUNT_W'(MAX_AXES)) begin
         limit = mmn_pkg::ACOUNT_W'(MAX_AXES);
      end else begin
         limit = acount_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      dropped_in = dropped_ff;
      weight_in  = weight_ff;
      axis_in    = axis_ff;
      rvalid_in  = 1'b0;
      rnorm_in   = rnorm_ff;
      reos_in    = reos_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (req_sample < min_ff) min_in = req_sample;
                  if (req_sample > max_ff) max_in = req_sample;
               end
               if (req_last) begin
                  idx_in   = '0;
                  state_in = S_RANGE;
               end
            end
         end
         S_RANGE:  state_in = S_READ;
         S_READ:   state_in = S_MUL;
         S_MUL:    state_in = S_LAUNCH;
         S_LAUNCH: state_in = S_WAIT;
         S_WAIT: begin
            if (div_rsp.done) begin
               rvalid_in = 1'b1;
               rnorm_in  = quot_clamped;
               reos_in   = last_idx;
               if (last_idx) begin
                  state_in = S_WRAP;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_WRAP: begin
            // end of set: advance axis, decay or restore weight, clear the set
            if ((mmn_pkg::ACOUNT_W'(axis_ff) + 1'b1) >= limit) begin
               axis_in   = '0;
               weight_in = mmn_pkg::ONE_Q16;
            end else begin
               axis_in   = axis_ff + 1'b1;
               weight_in = wnext;
            end
            count_in   = '0;
            min_in     = {1'b0, {(mmn_pkg::SAMPLE_W-1){1'b1}}};
            max_in     = {1'b1, {(mmn_pkg::SAMPLE_W-1){1'b0}}};
            dropped_in = 1'b0;
            state_in   = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         idx_ff     <= '0;
         min_ff     <= {1'b0, {(mmn_pkg::SAMPLE_W-1){1'b1}}};
         max_ff     <= {1'b1, {(mmn_pkg::SAMPLE_W-1){1'b0}}};
         dropped_ff <= 1'b0;
         weight_ff  <= mmn_pkg::ONE_Q16;
         axis_ff    <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         dropped_ff <= dropped_in;
         weight_ff  <= weight_in;
         axis_ff    <= axis_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   // configuration registers, picked up at the next end of set
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= mmn_pkg::ONE_Q16;
         acount_ff <= mmn_pkg::ACOUNT_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            mmn_pkg::CSR_WEIGHT_DECAY: decay_ff  <= csr_write_data[mmn_pkg::WEIGHT_W-1:0];
            mmn_pkg::CSR_AXIS_COUNT:   acount_ff <= csr_write_data[mmn_pkg::ACOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rnorm_ff <= rnorm_in;
      reos_ff  <= reos_in;
      if (state_ff == S_RANGE) begin
         range_ff <= mmn_pkg::RANGE_W'({max_ff[mmn_pkg::SAMPLE_W-1], max_ff}
                                       - {min_ff[mmn_pkg::SAMPLE_W-1], min_ff});
      end
      if (state_ff == S_MUL) begin
         prod_ff <= prod_full;
      end
   end

   // store: written while loading, read during the emission pass
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[count_ff[ADDR_W-1:0]] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_data_ff <= store_mem[idx_ff];
      end
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_normalized  = rnorm_ff;
   assign rsp_axis_number = axis_ff;
   assign rsp_end_of_set  = reos_ff;
   assign rsp_overflow    = dropped_ff;

   // results only come out during the emission pass
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside emission pass");

   // final result of a set is followed by a return to loading
   a_eos_then_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_set) |=> !busy)
      else $error("block not idle after end of set");

   // an accepted last item always starts the emission pass
   a_last_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> busy)
      else $error("last item did not start emission");

   // fill count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

endmodule

@@ sim/tb.sv @@
// self-checking testbench for min_max_normalizer: directed table, then random item sets
// depends on mmn_pkg and min_max_normalizer; keeps its own shadow of the store and weight
`timescale 1ns / 1ps

module tb;

   localparam int STORE_DEPTH = 64;
   localparam int AXES_MAX    = 8;
   localparam int QUIET_LIMIT = 1000;   // cycles with no item taken and no result
   localparam int SETTLE      = 25;     // weight/axis update after the final result
   localparam int DIRECTED_N  = 14;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic signed [mmn_pkg::SAMPLE_W-1:0] req_sample;
   logic                  req_last;
   logic                  rsp_valid;
   logic [mmn_pkg::NORM_W-1:0]     rsp_normalized;
   logic [mmn_pkg::AXIS_W-1:0]     rsp_axis_number;
   logic                  rsp_end_of_set;
   logic                  rsp_overflow;
   logic                  csr_write_en;
   logic                  csr_index;
   logic [mmn_pkg::CSR_W-1:0]      csr_write_data;

   min_max_normalizer #(
      .MAX_SAMPLES(STORE_DEPTH),
      .MAX_AXES   (AXES_MAX)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_normalized (rsp_normalized),
      .rsp_axis_number(rsp_axis_number),
      .rsp_end_of_set (rsp_end_of_set),
      .rsp_overflow   (rsp_overflow),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct packed {
      logic [mmn_pkg::NORM_W-1:0] norm;
      logic [mmn_pkg::AXIS_W-1:0] axis;
      logic              eos;
      logic              ovf;
   } norm_result_type;

   // one row of the directed table; typed rows carry their normalized value
   typedef struct {
      logic signed [mmn_pkg::SAMPLE_W-1:0] sample;
      bit                         last;
      bit                         typed;
      logic [mmn_pkg::NORM_W-1:0]          norm;
   } stim_row_type;

   norm_result_type pending_results[$];
   bit           failed = 1'b0;

   // shadow copy of the block state and its registers
   logic signed [mmn_pkg::SAMPLE_W-1:0] shadow_store [STORE_DEPTH];
   bit                         typed_valid  [STORE_DEPTH];
   logic [mmn_pkg::NORM_W-1:0]          typed_norm   [STORE_DEPTH];
   int                         shadow_count;
   logic signed [mmn_pkg::SAMPLE_W-1:0] shadow_lo;
   logic signed [mmn_pkg::SAMPLE_W-1:0] shadow_hi;
   logic [mmn_pkg::WEIGHT_W-1:0]        shadow_weight;
   logic [mmn_pkg::AXIS_W-1:0]          shadow_axis;
   bit                         shadow_dropped;
   logic [mmn_pkg::WEIGHT_W-1:0]        decay_reg;
   logic [mmn_pkg::ACOUNT_W-1:0]        axes_reg;

   stim_row_type directed_rows [DIRECTED_N] = '{
      '{32'sh0000_0000, 1'b1, 1'b1, 17'd0},       // lone item: zero range
      '{32'sh8000_0000, 1'b0, 1'b1, 17'd0},       // most negative is the minimum
      '{32'sh0000_0000, 1'b0, 1'b0, 17'd0},       // midpoint of the full range
      '{32'sh7FFF_FFFF, 1'b1, 1'b1, 17'h10000},   // most positive maps to 1.0
      '{32'sh0005_0000, 1'b0, 1'b1, 17'd0},       // equal items give zeros
      '{32'sh0005_0000, 1'b1, 1'b1, 17'd0},
      '{32'sh0001_8000, 1'b0, 1'b0, 17'd0},       // ordinary mixed-sign set
      '{32'shFFFD_C000, 1'b0, 1'b0, 17'd0},
      '{32'sh0003_0000, 1'b0, 1'b0, 17'd0},
      '{32'sh0000_C000, 1'b1, 1'b0, 17'd0},
      '{32'shFFFF_FFFF, 1'b0, 1'b0, 17'd0},       // all negative, min arrives last
      '{32'shFFFF_0000, 1'b1, 1'b0, 17'd0},
      '{32'sh7FFF_FFFF, 1'b0, 1'b0, 17'd0},       // range of one lsb at the top
      '{32'sh7FFF_FFFE, 1'b1, 1'b0, 17'd0}
   };

   function automatic void clear_shadow_set();
      shadow_count   = 0;
      shadow_lo      = 32'sh7FFF_FFFF;
      shadow_hi      = 32'sh8000_0000;
      shadow_dropped = 1'b0;
   endfunction

   // fold one taken item into the shadow; on last, queue the whole set of results
   task automatic track_sample(input logic signed [mmn_pkg::SAMPLE_W-1:0] s, input bit lst,
                               input bit typed, input logic [mmn_pkg::NORM_W-1:0] tnorm);
      longint       span;
      longint       diff;
      longint       quo;
      longint       next_w;
      int           lim;
      norm_result_type r;
      if (shadow_count < STORE_DEPTH) begin
         shadow_store[shadow_count] = s;
         typed_valid[shadow_count]  = typed;
         typed_norm[shadow_count]   = tnorm;
         shadow_count++;
         if (s < shadow_lo) shadow_lo = s;
         if (s > shadow_hi) shadow_hi = s;
      end else begin
         // store full: item dropped, bounds untouched
         shadow_dropped = 1'b1;
      end
      if (!lst) return;

      span = longint'(shadow_hi) - longint'(shadow_lo);
      for (int i = 0; i < shadow_count; i++) begin
         quo = 0;
         if (span != 0) begin
            diff = longint'(shadow_store[i]) - longint'(shadow_lo);
            quo  = (diff * longint'(shadow_weight)) / span;
            if (quo > 65536) quo = 65536;
         end
         r.norm = typed_valid[i] ? typed_norm[i] : quo[mmn_pkg::NORM_W-1:0];
         r.axis = shadow_axis;
         r.eos  = (i == shadow_count - 1);
         r.ovf  = shadow_dropped;
         pending_results.push_back(r);
      end

      // axis count 0 acts as 1, anything above the axis limit acts as the limit
      lim = (axes_reg == 0) ? 1 : (axes_reg > AXES_MAX) ? AXES_MAX : int'(axes_reg);
      next_w = (longint'(shadow_weight) * longint'(decay_reg)) >>> 16;
      if (next_w > 131071) next_w = 131071;
      if (int'(shadow_axis) + 1 >= lim) begin
         shadow_axis   = '0;
         shadow_weight = mmn_pkg::ONE_Q16;
      end else begin
         shadow_axis   = shadow_axis + 1'b1;
         shadow_weight = next_w[mmn_pkg::WEIGHT_W-1:0];
      end
      clear_shadow_set();
   endtask

   // offer one item after a gap, hold it until taken
   task automatic push_sample(input logic signed [mmn_pkg::SAMPLE_W-1:0] s, input bit lst,
                              input bit typed, input logic [mmn_pkg::NORM_W-1:0] tnorm,
                              input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      <= 1'b1;
      req_sample <= s;
      req_last   <= lst;
      do @(posedge clock); while (busy);
      track_sample(s, lst, typed, tnorm);
   endtask

   // drop start, wait out every queued result and the weight/axis update
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [mmn_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      if (idx == mmn_pkg::CSR_WEIGHT_DECAY) decay_reg = val[mmn_pkg::WEIGHT_W-1:0];
      else                                  axes_reg  = val[mmn_pkg::ACOUNT_W-1:0];
   endtask

   // random item value by set flavor: wide, clustered around a base, or constant
   function automatic logic signed [mmn_pkg::SAMPLE_W-1:0] draw_value(input int mode,
                                                              input logic [31:0] base);
      logic [31:0] v;
      case (mode)
         0: begin
            v = $urandom;
            if ($urandom_range(0, 15) == 0)
               v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
         1: v = base + $urandom_range(0, 2000) - 32'd1000;
         default: v = base;
      endcase
      return v;
   endfunction

   // result checker: results cannot be held off, so every strobe is taken
   norm_result_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: normalized %0d axis %0d", rsp_normalized,
                   rsp_axis_number);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_normalized !== want.norm) begin
               $error("normalized: expected %0d, got %0d", want.norm, rsp_normalized);
               failed = 1'b1;
            end
            if (rsp_axis_number !== want.axis) begin
               $error("axis_number: expected %0d, got %0d", want.axis, rsp_axis_number);
               failed = 1'b1;
            end
            if (rsp_end_of_set !== want.eos) begin
               $error("end_of_set: expected %0d, got %0d", want.eos, rsp_end_of_set);
               failed = 1'b1;
            end
            if (rsp_overflow !== want.ovf) begin
               $error("overflow: expected %0d, got %0d", want.ovf, rsp_overflow);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on quiet cycles
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("min_max_normalizer verification failed");
            $finish;
         end
      end
   end

   // register settings per random phase, extremes first; later phases draw random settings
   logic [mmn_pkg::WEIGHT_W-1:0] phase_decay [6] = '{17'd0, 17'h1FFFF, 17'd32768, 17'd65535,
                                                     17'd49152, 17'd65536};
   logic [mmn_pkg::ACOUNT_W-1:0] phase_axes  [6] = '{4'd8, 4'd2, 4'd3, 4'd0, 4'd15, 4'd1};

   initial begin
      int          phase;
      int          random_items;
      int          phase_items;
      int          phase_sets;
      int          set_size;
      int          mode;
      int          gap;
      int          lim;
      bit          no_idle;
      logic [31:0] base;
      logic [mmn_pkg::WEIGHT_W-1:0] dec_val;
      logic [mmn_pkg::ACOUNT_W-1:0] ax_val;

      reset          = 1'b1;
      start          = 1'b0;
      req_sample     = '0;
      req_last       = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = mmn_pkg::CSR_WEIGHT_DECAY;
      csr_write_data = '0;
      // shadow reset values
      clear_shadow_set();
      shadow_weight = mmn_pkg::ONE_Q16;
      shadow_axis   = '0;
      decay_reg     = mmn_pkg::ONE_Q16;
      axes_reg      = 4'd1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table under the reset register values
      foreach (directed_rows[k])
         push_sample(directed_rows[k].sample, directed_rows[k].last,
                     directed_rows[k].typed, directed_rows[k].norm,
                     $urandom_range(0, 13));

      // random phases: each opens with register writes while the block is idle
      phase        = 0;
      random_items = 0;
      while (phase < 6 || random_items < 160 - DIRECTED_N) begin
         drain();
         if (phase < 6) begin
            dec_val = phase_decay[phase];
            ax_val  = phase_axes[phase];
         end else begin
            dec_val = mmn_pkg::WEIGHT_W'($urandom_range(0, 131071));
            ax_val  = mmn_pkg::ACOUNT_W'($urandom_range(0, 15));
         end
         write_csr(mmn_pkg::CSR_WEIGHT_DECAY, mmn_pkg::CSR_W'(dec_val));
         write_csr(mmn_pkg::CSR_AXIS_COUNT, mmn_pkg::CSR_W'(ax_val));
         lim     = (ax_val == 0) ? 1 : (ax_val > AXES_MAX) ? AXES_MAX : int'(ax_val);
         no_idle = (phase % 3 == 2);   // back-to-back items for this whole phase
         phase_items = 0;
         phase_sets  = 0;
         // enough sets to wrap the axis index at least once
         while (phase_items < 12 || phase_sets < lim + 1) begin
            set_size = $urandom_range(1, 4);
            // one set that overruns the store early on
            if (phase == 1 && phase_sets == 0) set_size = STORE_DEPTH + 2;
            mode = $urandom_range(0, 2);
            base = $urandom;
            for (int j = 0; j < set_size; j++) begin
               gap = no_idle ? 0 : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
               push_sample(draw_value(mode, base), j == set_size - 1, 1'b0, '0, gap);
               phase_items++;
               random_items++;
            end
            phase_sets++;
         end
         phase++;
      end

      drain();
      if (failed) begin
         $display("min_max_normalizer verification failed");
      end else begin
         $display("min_max_normalizer verification clean");
      end
      $finish;
   end

endmodule
